FILE: sv/kvrt_pkg.sv
// ----------------------------------------------------------------------------
// kvrt_pkg
// Shared types and constants for the key/value record tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package kvrt_pkg;

  // Parser phase. Codes outside the list are treated as searching.
  typedef enum logic [2:0] {
    PH_SEARCH = 3'd0,
    PH_NAME   = 3'd1,
    PH_VSTART = 3'd2,
    PH_QUOTED = 3'd3,
    PH_ESCAPE = 3'd4,
    PH_DIGITS = 3'd5
  } phase_t;

  // Result kinds carried on out_kind.
  localparam logic [2:0] K_NAME    = 3'd0;
  localparam logic [2:0] K_VALUE   = 3'd1;
  localparam logic [2:0] K_END_NOV = 3'd2;
  localparam logic [2:0] K_END_VAL = 3'd3;
  localparam logic [2:0] K_FMT_ERR = 3'd4;
  localparam logic [2:0] K_ESC_ERR = 3'd5;

  // Input kinds.
  localparam logic IN_BYTE = 1'b0;
  localparam logic IN_EOF  = 1'b1;

  // Characters the parser compares against.
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_D0     = 8'h30;
  localparam logic [7:0] CH_D9     = 8'h39;

endpackage

`default_nettype wire

FILE: sv/key_value_record_tokenizer.sv
// ----------------------------------------------------------------------------
// key_value_record_tokenizer
// Splits a settings text byte stream into name and value tokens, record ends
// and error markers.
// ----------------------------------------------------------------------------
//
//   channel  handshake             payload
//   -------  --------------------  -----------------------
//   input    in_valid / in_ready   kind, in_byte
//   output   out_valid / out_ready out_kind, out_byte
//
// An item is registered on acceptance and parsed from the input register; its
// result (if any) lands in the output register. One item per cycle is sustained
// unless the output stalls; the single phase register is the only state carried
// from item to item. Items that give no result are consumed silently. rst
// clears the phase and both valid flags. A stall on the output holds the
// registered input item; in_ready drops only while that item waits.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_record_tokenizer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       kind,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_kind,
  output logic [7:0]      out_byte
);
  import kvrt_pkg::*;

  // Input register.
  logic       hold_valid;
  logic       hold_kind;
  logic [7:0] hold_byte;

  // Parser state.
  phase_t phase;
  phase_t phase_next;

  // Result of the item in the input register.
  logic       res_valid;
  logic [2:0] res_kind;
  logic [7:0] res_byte;

  logic advance;
  logic is_digit;

  // The held item moves on when the output slot is free or being drained.
  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;
  assign is_digit = (hold_byte >= CH_D0) && (hold_byte <= CH_D9);

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      hold_kind <= kind;
      hold_byte <= in_byte;
    end
  end

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (hold_kind == IN_EOF) begin
      phase_next = PH_SEARCH;
    end else begin
      unique case (phase) inside
        PH_NAME: begin
          if (hold_byte == CH_SP || hold_byte == CH_TAB ||
              hold_byte == CH_LF || hold_byte == CH_CR) begin
            phase_next = PH_SEARCH;
          end else if (hold_byte == CH_EQ) begin
            phase_next = PH_VSTART;
          end
        end
        PH_VSTART, PH_DIGITS: begin
          if (phase == PH_VSTART && hold_byte == CH_QUOTE) begin
            phase_next = PH_QUOTED;
          end else if (hold_byte == CH_LF) begin
            phase_next = PH_SEARCH;
          end else if (hold_byte == CH_CR || is_digit) begin
            phase_next = PH_DIGITS;
          end else begin
            phase_next = PH_SEARCH;
          end
        end
        PH_QUOTED: begin
          if (hold_byte == CH_QUOTE) begin
            phase_next = PH_SEARCH;
          end else if (hold_byte == CH_BSLASH) begin
            phase_next = PH_ESCAPE;
          end
        end
        PH_ESCAPE: begin
          if (hold_byte == CH_QUOTE || hold_byte == CH_BSLASH) begin
            phase_next = PH_QUOTED;
          end else begin
            phase_next = PH_SEARCH;
          end
        end
        default: begin
          if (hold_byte == CH_LF || hold_byte == CH_CR ||
              hold_byte == CH_SP || hold_byte == CH_QUOTE) begin
            phase_next = PH_SEARCH;
          end else begin
            phase_next = PH_NAME;
          end
        end
      endcase
    end
  end

  // Result of the held item.
  always_comb begin
    res_valid = 1'b1;
    res_kind  = K_FMT_ERR;
    res_byte  = 8'h00;
    if (hold_kind == IN_EOF) begin
      res_valid = (phase == PH_NAME) || (phase == PH_VSTART) ||
                  (phase == PH_QUOTED) || (phase == PH_ESCAPE) ||
                  (phase == PH_DIGITS);
    end else begin
      unique case (phase) inside
        PH_NAME: begin
          if (hold_byte == CH_SP || hold_byte == CH_TAB) begin
            res_kind = K_FMT_ERR;
          end else if (hold_byte == CH_LF || hold_byte == CH_CR) begin
            res_kind = K_END_NOV;
          end else if (hold_byte == CH_EQ) begin
            res_valid = 1'b0;
          end else begin
            res_kind = K_NAME;
            res_byte = hold_byte;
          end
        end
        PH_VSTART, PH_DIGITS: begin
          if (phase == PH_VSTART && hold_byte == CH_QUOTE) begin
            res_valid = 1'b0;
          end else if (hold_byte == CH_LF) begin
            res_kind = K_END_VAL;
          end else if (hold_byte == CH_CR) begin
            res_valid = 1'b0;
          end else if (is_digit) begin
            res_kind = K_VALUE;
            res_byte = hold_byte;
          end else begin
            res_kind = K_FMT_ERR;
          end
        end
        PH_QUOTED: begin
          if (hold_byte == CH_QUOTE) begin
            res_kind = K_END_VAL;
          end else if (hold_byte == CH_BSLASH) begin
            res_valid = 1'b0;
          end else begin
            res_kind = K_VALUE;
            res_byte = hold_byte;
          end
        end
        PH_ESCAPE: begin
          if (hold_byte == CH_QUOTE || hold_byte == CH_BSLASH) begin
            res_kind = K_VALUE;
            res_byte = hold_byte;
          end else begin
            res_kind = K_ESC_ERR;
          end
        end
        default: begin
          if (hold_byte == CH_LF || hold_byte == CH_CR ||
              hold_byte == CH_SP || hold_byte == CH_QUOTE) begin
            res_valid = 1'b0;
          end else begin
            res_kind = K_NAME;
            res_byte = hold_byte;
          end
        end
      endcase
    end
  end

  // Phase register and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SEARCH;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        phase <= phase_next;
      end
      if (advance) begin
        out_valid <= res_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance && res_valid) begin
      out_kind <= res_kind;
      out_byte <= res_byte;
    end
  end

endmodule

`default_nettype wire

FILE: sv/kvrt_checker.sv
// ----------------------------------------------------------------------------
// kvrt_checker
// Port-level checks on the key/value record tokenizer, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kvrt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_kind,
  input wire logic [7:0] out_byte
);
  import kvrt_pkg::*;

  // A stalled item keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte))
    else $error("output item changed while stalled");

  // Only defined result kinds appear.
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_kind <= K_ESC_ERR)
    else $error("undefined output kind");

  // Record ends and errors carry no byte.
  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != K_NAME && out_kind != K_VALUE |-> out_byte == 8'h00)
    else $error("marker item with nonzero byte");

  // Nothing can come out in the cycle after reset: an item needs two stages.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // The input side stalls only while an output item is blocked.
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

endmodule

bind key_value_record_tokenizer kvrt_checker u_kvrt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_kind  (out_kind),
  .out_byte  (out_byte)
);

`default_nettype wire
